// ----- hdl/dks_pkg.sv -----
// Shared types and constants for the deck store with shuffle.
// Used by the modulo unit and the top-level sequencer.
`timescale 1ns / 1ps

package dks_pkg;

	// Generator constants: x = LCG_MUL * s + LCG_ADD, wrapping at 32 bits.
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;

	// The swap draw is bits [19:5] of the generator value, a range of 32768.
	localparam int RAND_SHIFT = 5;
	localparam int RAND_W     = 15;
	localparam int RAND_CNT_W = 4;

	// Seed value after reset.
	localparam logic [31:0] SEED_RESET = 32'd1;

	// Operation codes carried by the kind field.
	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_SHUFFLE = 2'd1,
		KIND_DRAW    = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_ADD  = 8'b0000_0100,
		ST_DIV  = 8'b0000_1000,
		ST_RD   = 8'b0001_0000,
		ST_WR1  = 8'b0010_0000,
		ST_WR2  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

endpackage

// ----- hdl/deck_store_with_lcg_shuffle.sv -----
// Top level of the deck store: sequencer, generator, counters and result register.
// Depends on dks_pkg, dks_mod_unit and dks_store.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries one operation item: kind and
// card_in. Add pushes card_in, draw pops the top entry, shuffle runs a
// Fisher-Yates pass over the held entries, clear empties the stack and loads
// the generator from the seed register. Each item gives one result item on
// the output channel (out_valid/out_ready): card_out, remaining and status.
// The seed register is written through cfg_valid/cfg_ready with seed_value;
// the user must write it only while the block is idle; the block itself does
// not enforce this. cfg_ready is always high. A shuffle of n entries makes n-1
// swaps, each through the generator multiply and add, the 15 one-bit steps of
// the shared remainder unit, a read of both entries and the swap through the
// single write port of the store. Add and clear skip the read state a draw uses.
// The block takes one item at a time; in_ready is high only when it is idle.
// A finished result waits in the output register while the next item is
// accepted and worked on; that item's result waits in turn until out_ready.
// Reset clears the count, sets generator and seed to one and drops out_valid;
// store contents are undefined until written.
module deck_store_with_lcg_shuffle #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [31:0]                      seed_value,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       kind,
	input  logic [7:0]                       card_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       card_out,
	output logic [$clog2(DEPTH+1)-1:0]       remaining,
	output logic [1:0]                       status
);
	import dks_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	state_t             state_q;
	logic [31:0]        seed_q;
	logic [31:0]        gen_q;
	logic [31:0]        prod_q;
	logic [31:0]        gen_next;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   p_q;
	logic [7:0]         res_card_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [7:0]         card_out_q;
	logic [CNT_W-1:0]   remaining_q;
	status_t            status_q;
	logic               in_acc;
	logic               out_free;
	kind_t              kind_in;
	logic [CNT_W-1:0]   bound;
	logic               mod_done;
	logic [CNT_W-1:0]   mod_rem;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [7:0]         wr_data;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr_a;
	logic [7:0]         rd_data_a;
	logic [7:0]         rd_data_b;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign kind_in   = kind_t'(kind);
	assign bound     = CNT_W'(i_q) + CNT_W'(1);
	assign gen_next  = prod_q + LCG_ADD;

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= seed_value;
		end
	end

	// Shared remainder unit: draw mod (i+1).
	dks_mod_unit #(
		.DIV_W(CNT_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_ADD),
		.dividend(gen_next[RAND_SHIFT +: RAND_W]),
		.divisor (bound),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Store port selection.
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = IDX_W'(count_q);
		wr_data   = card_in;
		rd_en     = 1'b0;
		rd_addr_a = p_q;
		if (in_acc && kind_in == KIND_ADD && count_q != CNT_W'(DEPTH)) begin
			wr_en = 1'b1;
		end
		if (in_acc && kind_in == KIND_DRAW) begin
			rd_en     = 1'b1;
			rd_addr_a = IDX_W'(count_q - CNT_W'(1));
		end
		if (state_q == ST_RD) begin
			rd_en = 1'b1;
		end
		if (state_q == ST_WR1) begin
			wr_en   = 1'b1;
			wr_addr = p_q;
			wr_data = rd_data_b;
		end
		if (state_q == ST_WR2) begin
			wr_en   = 1'b1;
			wr_addr = i_q;
			wr_data = rd_data_a;
		end
	end

	dks_store #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(i_q),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	// Generator multiply stage; the low 32 bits are the wrapped product.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= gen_q * LCG_MUL;
		end
	end

	// Sequencer, counters and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			gen_q        <= SEED_RESET;
			i_q          <= '0;
			p_q          <= '0;
			res_card_q   <= '0;
			res_status_q <= STATUS_OK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_card_q   <= '0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_FIN;
						unique case (kind_in)
							KIND_ADD: begin
								if (count_q == CNT_W'(DEPTH)) begin
									res_status_q <= STATUS_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							KIND_SHUFFLE: begin
								if (count_q >= CNT_W'(2)) begin
									i_q     <= IDX_W'(count_q - CNT_W'(1));
									state_q <= ST_MUL;
								end
							end
							KIND_DRAW: begin
								if (count_q == '0) begin
									res_status_q <= STATUS_EMPTY;
								end else begin
									count_q <= count_q - CNT_W'(1);
									state_q <= ST_RD;
								end
							end
							KIND_CLEAR: begin
								count_q <= '0;
								gen_q   <= seed_q;
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					gen_q   <= gen_next;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (mod_done) begin
						p_q     <= IDX_W'(mod_rem);
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// A draw comes here with its read already issued; its entry is
					// on read port A now.
					if (res_status_q == STATUS_OK && i_q == IDX_W'(0)) begin
						res_card_q <= rd_data_a;
						state_q    <= ST_FIN;
					end else begin
						state_q <= ST_WR1;
					end
				end
				ST_WR1: begin
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					if (i_q == IDX_W'(1)) begin
						i_q     <= '0;
						state_q <= ST_FIN;
					end else begin
						i_q     <= i_q - IDX_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			card_out_q  <= '0;
			remaining_q <= '0;
			status_q    <= STATUS_OK;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
			card_out_q  <= res_card_q;
			remaining_q <= count_q;
			status_q    <= res_status_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign card_out  = card_out_q;
	assign remaining = remaining_q;
	assign status    = status_q;

	// The count never passes the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds capacity");

	// The remainder unit reports only while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_DIV)
		else $error("remainder done outside the wait state");

	// The swap position never passes the current top index.
	a_swap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && mod_done) |-> mod_rem < bound)
		else $error("swap position out of range");

	// A swap step is never started for index zero.
	a_swap_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> i_q != '0)
		else $error("swap started at index zero");

endmodule

// ----- hdl/dks_mod_unit.sv -----
// Iterative remainder unit: one restoring step per cycle over a 15-bit dividend.
// Depends on dks_pkg for the dividend width.
`timescale 1ns / 1ps

module dks_mod_unit #(
	parameter int DIV_W = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dks_pkg::RAND_W-1:0]    dividend,
	input  logic [DIV_W-1:0]              divisor,
	output logic                          done,
	output logic [DIV_W-1:0]              rem
);
	import dks_pkg::*;

	logic                  run_q;
	logic                  done_q;
	logic [RAND_CNT_W-1:0] cnt_q;
	logic [RAND_W-1:0]     num_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      div_q;
	logic [DIV_W:0]        trial;
	logic [DIV_W:0]        diff;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, num_q[RAND_W-1]};
	assign diff  = trial - {1'b0, div_q};

	// Control of the step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + RAND_CNT_W'(1);
				if (cnt_q == RAND_CNT_W'(RAND_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the remainder; the partial remainder stays below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[RAND_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/dks_store.sv -----
// Entry store: one write port and two read ports with registered read data.
// Depends on dks_pkg only by convention; no package items are needed here.
`timescale 1ns / 1ps

module dks_store #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr_a,
	input  logic [IDX_W-1:0] rd_addr_b,
	output logic [7:0]       rd_data_a,
	output logic [7:0]       rd_data_b
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_a_q;
	logic [7:0] rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read ports; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ----- bench/deck_store_with_lcg_shuffle_tb.sv -----
// Self-checking bench for the deck store with shuffle: random operation traffic
// against an in-bench model of the stack, the generator and the seed register.
// Depends on dks_pkg and the deck_store_with_lcg_shuffle RTL.
`timescale 1ns / 1ps

module deck_store_with_lcg_shuffle_tb;
	import dks_pkg::*;

	localparam int DECK_DEPTH    = 64;
	localparam int ITEM_TARGET   = 540;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 6000000;
	localparam int PRINT_LIMIT   = 100;

	// One result item as the block should return it.
	typedef struct {
		logic [7:0] card;
		logic [6:0] left;
		status_t    code;
	} reply_t;

	// Mirror of the stack, the generator and the seed, plus the replies owed.
	class deck_mirror;
		logic [7:0]  cards [DECK_DEPTH];
		int unsigned held;
		logic [31:0] lcg;
		logic [31:0] seed;
		reply_t      replies_due [$];
		int          mismatches;

		function new();
			held = 0;
			lcg = SEED_RESET;
			seed = SEED_RESET;
			mismatches = 0;
			foreach (cards[i]) cards[i] = '0;
		endfunction

		function void set_seed(logic [31:0] value);
			seed = value;
		endfunction

		// Apply one accepted operation and queue the reply it must produce.
		function void play_op(kind_t op, logic [7:0] card);
			reply_t r;
			logic [7:0] t;
			logic [RAND_W-1:0] pick;
			int pos;
			r.card = '0;
			r.code = STATUS_OK;
			case (op)
				KIND_ADD: begin
					if (held >= DECK_DEPTH) begin
						r.code = STATUS_FULL;
					end else begin
						cards[held] = card;
						held++;
					end
				end
				KIND_SHUFFLE: begin
					// Fisher-Yates from the top entry down to index 1.
					for (int i = int'(held) - 1; i > 0; i--) begin
						lcg = lcg * LCG_MUL + LCG_ADD;
						pick = lcg[RAND_SHIFT +: RAND_W];
						pos = int'(pick) % (i + 1);
						t = cards[pos];
						cards[pos] = cards[i];
						cards[i] = t;
					end
				end
				KIND_DRAW: begin
					if (held == 0) begin
						r.code = STATUS_EMPTY;
					end else begin
						held--;
						r.card = cards[held];
					end
				end
				default: begin
					held = 0;
					lcg = seed;
				end
			endcase
			r.left = 7'(held);
			replies_due.push_back(r);
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("%0t mismatch: %s", $time, what);
		endtask

		// Compare one accepted result item with the oldest reply owed.
		task match_reply(logic [7:0] card, logic [6:0] left, logic [1:0] code);
			reply_t want;
			if (replies_due.size() == 0) begin
				flag_mismatch("result item with no operation outstanding");
				return;
			end
			want = replies_due.pop_front();
			if (card !== want.card)
				flag_mismatch($sformatf("card_out %h, want %h", card, want.card));
			if (left !== want.left)
				flag_mismatch($sformatf("remaining %0d, want %0d", left, want.left));
			if (code !== want.code)
				flag_mismatch($sformatf("status %0d, want %0d", code, want.code));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] seed_value;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  card_in;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  card_out;
	logic [6:0]  remaining;
	logic [1:0]  status;

	deck_mirror mirror = new();
	int  sent;
	bit  in_gaps;
	bit  out_gaps;
	bit  hold_out;
	int  cycle_count;

	deck_store_with_lcg_shuffle #(
		.DEPTH(DECK_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.seed_value(seed_value),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.card_in(card_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.card_out(card_out),
		.remaining(remaining),
		.status(status)
	);

	// Clock starts low so that the first rising edge comes with reset applied.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one operation item and wait until the block takes it.
	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input kind_t op, input logic [7:0] card);
		int gap;
		gap = in_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		card_in <= card;
		do @(posedge clk); while (!in_ready);
		mirror.play_op(op, card);
		sent++;
		@(negedge clk);
	endtask

	// Stop offering items; called at a falling edge.
	task automatic go_quiet();
		in_valid <= 1'b0;
	endtask

	// Wait until every owed result item has come back, then realign to a falling edge.
	task automatic drain();
		while (mirror.replies_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the seed register; only called while the block is idle.
	task automatic write_seed(input logic [31:0] value);
		cfg_valid <= 1'b1;
		seed_value <= value;
		do @(posedge clk); while (!cfg_ready);
		mirror.set_seed(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One round of traffic: mostly a fresh deck that is filled, shuffled and
	// drawn from, sometimes a burst of operations of any kind.
	task automatic play_round();
		int n;
		int draws;
		if ($urandom_range(0, 7) == 0) begin
			repeat (6) send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
		end else begin
			send_item(KIND_CLEAR, 8'($urandom));
			if ($urandom_range(0, 5) == 0)
				n = $urandom_range(DECK_DEPTH - 4, DECK_DEPTH + 3);
			else
				n = $urandom_range(0, 12);
			repeat (n) send_item(KIND_ADD, 8'($urandom));
			repeat ($urandom_range(1, 2)) send_item(KIND_SHUFFLE, 8'($urandom));
			draws = $urandom_range(0, n + 2);
			repeat (draws) begin
				case ($urandom_range(0, 7))
					0: send_item(KIND_SHUFFLE, 8'($urandom));
					1: send_item(KIND_ADD, 8'($urandom));
					default: ;
				endcase
				send_item(KIND_DRAW, 8'($urandom));
			end
		end
	endtask

	// Result side: random stalls per item, and one long hold when asked.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_out)
				stall = HOLD_CYCLES;
			else
				stall = out_gaps ? $urandom_range(0, 19) : 0;
			hold_out = 1'b0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			mirror.match_reply(card_out, remaining, status);
			@(negedge clk);
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("deck_store_with_lcg_shuffle_tb NOT OK");
		$finish;
	end

	// Stimulus: reset, directed corner cases, then phased random traffic.
	initial begin
		int phase_no;
		int phase_end;
		logic [31:0] next_seed;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		seed_value = '0;
		in_valid = 1'b0;
		kind = KIND_ADD;
		card_in = '0;
		sent = 0;
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		hold_out = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty-stack draw and shuffles of zero and one entries on the reset seed.
		send_item(KIND_DRAW, 8'($urandom));
		send_item(KIND_SHUFFLE, 8'($urandom));
		send_item(KIND_ADD, 8'h00);
		send_item(KIND_SHUFFLE, 8'($urandom));
		send_item(KIND_DRAW, 8'($urandom));
		send_item(KIND_ADD, 8'hFF);
		send_item(KIND_ADD, 8'h00);
		send_item(KIND_ADD, 8'hAA);
		send_item(KIND_ADD, 8'h55);
		send_item(KIND_ADD, 8'h01);
		send_item(KIND_SHUFFLE, 8'($urandom));
		send_item(KIND_DRAW, 8'($urandom));
		send_item(KIND_DRAW, 8'($urandom));
		send_item(KIND_CLEAR, 8'($urandom));
		send_item(KIND_DRAW, 8'($urandom));
		send_item(KIND_ADD, 8'h80);
		send_item(KIND_ADD, 8'h7F);
		send_item(KIND_SHUFFLE, 8'($urandom));
		go_quiet();
		drain();

		// All-ones seed, loaded by a clear.
		write_seed(32'hFFFF_FFFF);
		send_item(KIND_CLEAR, 8'($urandom));
		send_item(KIND_ADD, 8'h11);
		send_item(KIND_ADD, 8'h22);
		send_item(KIND_ADD, 8'h33);
		send_item(KIND_SHUFFLE, 8'($urandom));
		send_item(KIND_DRAW, 8'($urandom));

		// Random phases, each on a new seed and a new idling pattern.
		phase_no = 0;
		while (sent < ITEM_TARGET) begin
			go_quiet();
			drain();
			case (phase_no)
				0: next_seed = 32'h0000_0000;
				1: next_seed = 32'hFFFF_FFFF;
				2: next_seed = 32'h8000_0000;
				3: next_seed = SEED_RESET;
				default: next_seed = $urandom;
			endcase
			write_seed(next_seed);
			in_gaps = ($urandom_range(0, 3) != 0);
			out_gaps = ($urandom_range(0, 3) != 0);
			// Back-to-back offers against a long receiver hold fill the block.
			if (phase_no == 1) begin
				in_gaps = 1'b0;
				hold_out = 1'b1;
			end
			phase_end = sent + $urandom_range(60, 100);
			while (sent < phase_end && sent < ITEM_TARGET) play_round();
			phase_no++;
		end

		go_quiet();
		drain();
		repeat (50) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.replies_due.size() == 0)
			$display("deck_store_with_lcg_shuffle_tb OK");
		else
			$display("deck_store_with_lcg_shuffle_tb NOT OK");
		$finish;
	end

endmodule
